FILE: sv/slot_window_layout_core_assert.svh
// Assertion macros used by the slot window layout core.
`ifndef SLOT_WINDOW_LAYOUT_CORE_ASSERT_SVH
`define SLOT_WINDOW_LAYOUT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SWL_CHECK_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slot window layout: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SWL_CHECK_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slot window layout: next-cycle check failed");

`endif

FILE: sv/slotwin_pkg.sv
package slotwin_pkg;

  localparam int SRC_W      = 12;
  localparam int SCALE_W    = 11;
  localparam int ALPHA_W    = 8;
  localparam int SLOT_W     = 7;
  localparam int POS_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Scaled size before capping, and the product it comes from.
  localparam int UNITY_SHIFT = 8;
  localparam int PROD_W      = SRC_W + SCALE_W;
  localparam int DRAWN_W     = PROD_W - UNITY_SHIFT;

  // Divider: dividend is a scaled size times a usable extent.
  localparam int DVD_W   = DRAWN_W + SRC_W;
  localparam int QUOT_W  = DRAWN_W;
  localparam int TRIAL_W = DRAWN_W + QUOT_W;

  // Working width for position arithmetic.
  localparam int CALC_W = POS_W + 2;

  localparam int MARGIN_SIDE   = 32;
  localparam int MARGIN_TOP    = 48;
  localparam int MARGIN_BOTTOM = 48;

  localparam logic signed [POS_W-1:0] HIDDEN_POS = -15'sd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_SCALE_ACTIVE   = 3'd2,
    REG_SCALE_ADJACENT = 3'd3,
    REG_SCALE_FAR      = 3'd4,
    REG_ALPHA_ACTIVE   = 3'd5,
    REG_ALPHA_ADJACENT = 3'd6,
    REG_ALPHA_FAR      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SLOT_ACTIVE,
    SLOT_ADJACENT,
    SLOT_FAR,
    SLOT_HIDDEN
  } slot_class_t;

  typedef struct packed {
    logic [SRC_W-1:0]   screen_width;
    logic [SRC_W-1:0]   screen_height;
    logic [SCALE_W-1:0] scale_active;
    logic [SCALE_W-1:0] scale_adjacent;
    logic [SCALE_W-1:0] scale_far;
    logic [ALPHA_W-1:0] alpha_active;
    logic [ALPHA_W-1:0] alpha_adjacent;
    logic [ALPHA_W-1:0] alpha_far;
    logic [SRC_W-1:0]   usable_w;
    logic [SRC_W-1:0]   usable_h;
  } cfg_t;

  // Data that rides alongside a division.
  typedef struct packed {
    logic               hidden;
    logic signed [2:0]  slot;
    logic [ALPHA_W-1:0] alpha;
    logic [DRAWN_W-1:0] dw;
    logic [DRAWN_W-1:0] dh;
    logic               cap;
  } side_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [DVD_W-1:0]   dividend;
    logic [DRAWN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  // One restoring step: try the divisor shifted to the given quotient bit.
  function automatic div_step_t div_step(logic [DVD_W-1:0] rem,
                                         logic [DRAWN_W-1:0] dvs, int bit_idx);
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] rem_w;
    div_step_t          res;
    trial = TRIAL_W'(dvs) << bit_idx;
    rem_w = TRIAL_W'(rem);
    if (rem_w >= trial) begin
      res.rem  = DVD_W'(rem_w - trial);
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: sv/slotwin_cfg.sv
module slotwin_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [slotwin_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slotwin_pkg::CFG_DATA_W-1:0] cfg_data,
  output slotwin_pkg::cfg_t                  cfg
);

  logic [slotwin_pkg::SRC_W-1:0]   screen_width_r, screen_height_r;
  logic [slotwin_pkg::SCALE_W-1:0] scale_active_r, scale_adjacent_r, scale_far_r;
  logic [slotwin_pkg::ALPHA_W-1:0] alpha_active_r, alpha_adjacent_r, alpha_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r   <= 12'd1024;
      screen_height_r  <= 12'd768;
      scale_active_r   <= 11'd256;
      scale_adjacent_r <= 11'd192;
      scale_far_r      <= 11'd128;
      alpha_active_r   <= 8'd255;
      alpha_adjacent_r <= 8'd160;
      alpha_far_r      <= 8'd80;
    end else if (cfg_we) begin
      unique case (slotwin_pkg::cfg_reg_t'(cfg_index))
        slotwin_pkg::REG_SCREEN_WIDTH:   screen_width_r   <= cfg_data;
        slotwin_pkg::REG_SCREEN_HEIGHT:  screen_height_r  <= cfg_data;
        slotwin_pkg::REG_SCALE_ACTIVE:   scale_active_r   <= cfg_data[10:0];
        slotwin_pkg::REG_SCALE_ADJACENT: scale_adjacent_r <= cfg_data[10:0];
        slotwin_pkg::REG_SCALE_FAR:      scale_far_r      <= cfg_data[10:0];
        slotwin_pkg::REG_ALPHA_ACTIVE:   alpha_active_r   <= cfg_data[7:0];
        slotwin_pkg::REG_ALPHA_ADJACENT: alpha_adjacent_r <= cfg_data[7:0];
        slotwin_pkg::REG_ALPHA_FAR:      alpha_far_r      <= cfg_data[7:0];
      endcase
    end
  end

  // Usable area: screen less margins, floored at zero.
  localparam logic [slotwin_pkg::SRC_W-1:0] SIDE_SUM =
    12'(2 * slotwin_pkg::MARGIN_SIDE);
  localparam logic [slotwin_pkg::SRC_W-1:0] VERT_SUM =
    12'(slotwin_pkg::MARGIN_TOP + slotwin_pkg::MARGIN_BOTTOM);

  always_comb begin
    cfg.screen_width   = screen_width_r;
    cfg.screen_height  = screen_height_r;
    cfg.scale_active   = scale_active_r;
    cfg.scale_adjacent = scale_adjacent_r;
    cfg.scale_far      = scale_far_r;
    cfg.alpha_active   = alpha_active_r;
    cfg.alpha_adjacent = alpha_adjacent_r;
    cfg.alpha_far      = alpha_far_r;
    cfg.usable_w = (screen_width_r >= SIDE_SUM) ? screen_width_r - SIDE_SUM : '0;
    cfg.usable_h = (screen_height_r >= VERT_SUM) ? screen_height_r - VERT_SUM : '0;
  end

endmodule

FILE: sv/slotwin_div.sv
module slotwin_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [slotwin_pkg::DVD_W-1:0]   dividend,
  input  logic [slotwin_pkg::DRAWN_W-1:0] divisor,
  output logic [slotwin_pkg::QUOT_W-1:0]  quotient
);

  localparam int NSTG = slotwin_pkg::QUOT_W;

  logic [slotwin_pkg::DVD_W-1:0]   rem_r [NSTG];
  logic [slotwin_pkg::DRAWN_W-1:0] dvs_r [NSTG];
  logic [slotwin_pkg::QUOT_W-1:0]  quo_r [NSTG];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [slotwin_pkg::DVD_W-1:0]   rem_in;
    logic [slotwin_pkg::DRAWN_W-1:0] dvs_in;
    logic [slotwin_pkg::QUOT_W-1:0]  quo_in;
    slotwin_pkg::div_step_t          step;

    if (k == 0) begin : g_head
      assign rem_in = dividend;
      assign dvs_in = divisor;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign step = slotwin_pkg::div_step(rem_in, dvs_in, NSTG - 1 - k);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= step.rem;
        dvs_r[k] <= dvs_in;
        quo_r[k] <= quo_in | (NSTG'(step.qbit) << (NSTG - 1 - k));
      end
    end
  end

  assign quotient = quo_r[NSTG-1];

endmodule

FILE: sv/slotwin_front.sv
module slotwin_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [slotwin_pkg::SLOT_W-1:0] in_slot_offset,
  input  logic [slotwin_pkg::SRC_W-1:0]       in_source_width,
  input  logic [slotwin_pkg::SRC_W-1:0]       in_source_height,
  input  slotwin_pkg::cfg_t                   cfg,
  output slotwin_pkg::div_req_t               req
);

  slotwin_pkg::slot_class_t        cls;
  logic [slotwin_pkg::SCALE_W-1:0] scale;
  logic [slotwin_pkg::ALPHA_W-1:0] alpha;

  logic                            vld_a_r;
  logic                            hidden_a_r;
  logic signed [2:0]               slot_a_r;
  logic [slotwin_pkg::ALPHA_W-1:0] alpha_a_r;
  logic [slotwin_pkg::PROD_W-1:0]  prod_w_r, prod_h_r;

  logic [slotwin_pkg::DRAWN_W-1:0] dw0, dh0;
  slotwin_pkg::div_req_t           req_nxt, req_r;

  always_comb begin
    priority if (in_slot_offset == 7'sd0) begin
      cls = slotwin_pkg::SLOT_ACTIVE;
    end else if (in_slot_offset == 7'sd1 || in_slot_offset == -7'sd1) begin
      cls = slotwin_pkg::SLOT_ADJACENT;
    end else if (in_slot_offset == 7'sd2 || in_slot_offset == -7'sd2) begin
      cls = slotwin_pkg::SLOT_FAR;
    end else begin
      cls = slotwin_pkg::SLOT_HIDDEN;
    end

    unique case (cls)
      slotwin_pkg::SLOT_ACTIVE: begin
        scale = cfg.scale_active;
        alpha = cfg.alpha_active;
      end
      slotwin_pkg::SLOT_ADJACENT: begin
        scale = cfg.scale_adjacent;
        alpha = cfg.alpha_adjacent;
      end
      slotwin_pkg::SLOT_FAR: begin
        scale = cfg.scale_far;
        alpha = cfg.alpha_far;
      end
      default: begin
        scale = '0;
        alpha = '0;
      end
    endcase
  end

  // Stage A: scale both sides.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hidden_a_r <= (cls == slotwin_pkg::SLOT_HIDDEN);
      slot_a_r   <= in_slot_offset[2:0];
      alpha_a_r  <= alpha;
      prod_w_r   <= slotwin_pkg::PROD_W'(in_source_width) * slotwin_pkg::PROD_W'(scale);
      prod_h_r   <= slotwin_pkg::PROD_W'(in_source_height) * slotwin_pkg::PROD_W'(scale);
    end
  end

  // Stage B: test against usable width and form the first dividend.
  assign dw0 = prod_w_r[slotwin_pkg::PROD_W-1:slotwin_pkg::UNITY_SHIFT];
  assign dh0 = prod_h_r[slotwin_pkg::PROD_W-1:slotwin_pkg::UNITY_SHIFT];

  always_comb begin
    req_nxt.valid       = vld_a_r;
    req_nxt.side.hidden = hidden_a_r;
    req_nxt.side.slot   = slot_a_r;
    req_nxt.side.alpha  = alpha_a_r;
    req_nxt.side.dw     = dw0;
    req_nxt.side.dh     = dh0;
    req_nxt.side.cap    = dw0 > slotwin_pkg::DRAWN_W'(cfg.usable_w);
    req_nxt.dividend    = slotwin_pkg::DVD_W'(dh0) * slotwin_pkg::DVD_W'(cfg.usable_w);
    req_nxt.divisor     = dw0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (en) begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

FILE: sv/slot_window_layout_core.sv
// Pipeline: two scaling stages, two 15-stage restoring dividers, one join stage
//   and the output register.
// Throughput: one request per cycle; every stage advances together while the
//   output register is empty or being taken, and holds otherwise.
// Reset: synchronous, active low; clears all valid bits and reloads the
//   configuration registers with their defaults.
module slot_window_layout_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [slotwin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slotwin_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [slotwin_pkg::SLOT_W-1:0] in_slot_offset,
  input  logic [slotwin_pkg::SRC_W-1:0]         in_source_width,
  input  logic [slotwin_pkg::SRC_W-1:0]         in_source_height,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [slotwin_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [slotwin_pkg::POS_W-1:0]  out_pos_y,
  output logic [slotwin_pkg::SRC_W-1:0]         out_drawn_width,
  output logic [slotwin_pkg::SRC_W-1:0]         out_drawn_height,
  output logic [slotwin_pkg::ALPHA_W-1:0]       out_opacity
);

`include "slot_window_layout_core_assert.svh"

  localparam int NSTG   = slotwin_pkg::QUOT_W;
  localparam int CALC_W = slotwin_pkg::CALC_W;
  localparam int VLD_W  = 2 * NSTG + 3;

  slotwin_pkg::cfg_t     cfg;
  slotwin_pkg::div_req_t req1;
  slotwin_pkg::div_req_t req2_r, req2_nxt;

  logic pipe_en;

  logic [slotwin_pkg::QUOT_W-1:0] q1, q2;

  // Sideband shift lines running beside each divider.
  logic [NSTG-1:0]     vld1_r, vld2_r;
  slotwin_pkg::side_t  side1_r [NSTG];
  slotwin_pkg::side_t  side2_r [NSTG];

  slotwin_pkg::side_t  s1_tail, s2_tail;

  logic [slotwin_pkg::DRAWN_W-1:0] dw1, dh1, dw2, dh2;
  logic signed [CALC_W-1:0]        w_s, slot_term, px, py;

  logic                                 out_valid_r;
  logic signed [slotwin_pkg::POS_W-1:0] out_pos_x_r, out_pos_y_r;
  logic signed [slotwin_pkg::POS_W-1:0] out_pos_x_nxt, out_pos_y_nxt;
  logic [slotwin_pkg::SRC_W-1:0]        out_drawn_width_r, out_drawn_height_r;
  logic [slotwin_pkg::SRC_W-1:0]        out_drawn_width_nxt, out_drawn_height_nxt;
  logic [slotwin_pkg::ALPHA_W-1:0]      out_opacity_r, out_opacity_nxt;

  logic [VLD_W-1:0] pipe_vld;

  // Advance the whole pipe whenever the output register can take a result.
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  slotwin_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Slot decode, scaling and the first cap test.
  slotwin_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (pipe_en),
    .in_valid         (in_valid),
    .in_slot_offset   (in_slot_offset),
    .in_source_width  (in_source_width),
    .in_source_height (in_source_height),
    .cfg              (cfg),
    .req              (req1)
  );

  // First division: height rescaled after the width cap.
  slotwin_div u_div_w (
    .clk      (clk),
    .en       (pipe_en),
    .dividend (req1.dividend),
    .divisor  (req1.divisor),
    .quotient (q1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= '0;
    end else if (pipe_en) begin
      vld1_r <= {vld1_r[NSTG-2:0], req1.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side1_r[0] <= req1.side;
      for (int i = 1; i < NSTG; i++) begin
        side1_r[i] <= side1_r[i-1];
      end
    end
  end

  assign s1_tail = side1_r[NSTG-1];

  // Join stage: apply the width cap, test the height, form the second dividend.
  always_comb begin
    dh1 = s1_tail.cap ? q1 : s1_tail.dh;
    dw1 = s1_tail.cap ? slotwin_pkg::DRAWN_W'(cfg.usable_w) : s1_tail.dw;

    req2_nxt.valid       = vld1_r[NSTG-1];
    req2_nxt.side.hidden = s1_tail.hidden;
    req2_nxt.side.slot   = s1_tail.slot;
    req2_nxt.side.alpha  = s1_tail.alpha;
    req2_nxt.side.dw     = dw1;
    req2_nxt.side.dh     = dh1;
    req2_nxt.side.cap    = dh1 > slotwin_pkg::DRAWN_W'(cfg.usable_h);
    req2_nxt.dividend    = slotwin_pkg::DVD_W'(dw1) * slotwin_pkg::DVD_W'(cfg.usable_h);
    req2_nxt.divisor     = dh1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req2_r.valid <= 1'b0;
    end else if (pipe_en) begin
      req2_r <= req2_nxt;
    end
  end

  // Second division: width rescaled after the height cap.
  slotwin_div u_div_h (
    .clk      (clk),
    .en       (pipe_en),
    .dividend (req2_r.dividend),
    .divisor  (req2_r.divisor),
    .quotient (q2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= '0;
    end else if (pipe_en) begin
      vld2_r <= {vld2_r[NSTG-2:0], req2_r.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side2_r[0] <= req2_r.side;
      for (int i = 1; i < NSTG; i++) begin
        side2_r[i] <= side2_r[i-1];
      end
    end
  end

  assign s2_tail = side2_r[NSTG-1];

  // Final stage: apply the height cap and centre the window in its slot.
  always_comb begin
    dw2 = s2_tail.cap ? q2 : s2_tail.dw;
    dh2 = s2_tail.cap ? slotwin_pkg::DRAWN_W'(cfg.usable_h) : s2_tail.dh;

    w_s = signed'(CALC_W'(cfg.screen_width));
    unique case (s2_tail.slot)
      -3'sd2:  slot_term = -(w_s <<< 1);
      -3'sd1:  slot_term = -w_s;
      3'sd1:   slot_term = w_s;
      3'sd2:   slot_term = w_s <<< 1;
      default: slot_term = '0;
    endcase

    px = signed'(CALC_W'(cfg.screen_width >> 1)) + slot_term
         - signed'(CALC_W'(dw2 >> 1));
    py = signed'(CALC_W'(slotwin_pkg::MARGIN_TOP))
         + signed'(CALC_W'(cfg.usable_h >> 1))
         - signed'(CALC_W'(dh2 >> 1));

    if (s2_tail.hidden) begin
      out_pos_x_nxt        = slotwin_pkg::HIDDEN_POS;
      out_pos_y_nxt        = slotwin_pkg::HIDDEN_POS;
      out_drawn_width_nxt  = '0;
      out_drawn_height_nxt = '0;
      out_opacity_nxt      = '0;
    end else begin
      out_pos_x_nxt        = px[slotwin_pkg::POS_W-1:0];
      out_pos_y_nxt        = py[slotwin_pkg::POS_W-1:0];
      out_drawn_width_nxt  = dw2[slotwin_pkg::SRC_W-1:0];
      out_drawn_height_nxt = dh2[slotwin_pkg::SRC_W-1:0];
      out_opacity_nxt      = s2_tail.alpha;
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= vld2_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_pos_x_r        <= out_pos_x_nxt;
      out_pos_y_r        <= out_pos_y_nxt;
      out_drawn_width_r  <= out_drawn_width_nxt;
      out_drawn_height_r <= out_drawn_height_nxt;
      out_opacity_r      <= out_opacity_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = out_pos_x_r;
  assign out_pos_y        = out_pos_y_r;
  assign out_drawn_width  = out_drawn_width_r;
  assign out_drawn_height = out_drawn_height_r;
  assign out_opacity      = out_opacity_r;

  assign pipe_vld = {req1.valid, vld1_r, req2_r.valid, vld2_r, out_valid_r};

  // A visible window never exceeds the usable area.
  `SWL_CHECK_IMP(a_width_capped, clk, rst_n, out_valid_r && (out_pos_y_r != slotwin_pkg::HIDDEN_POS), out_drawn_width_r <= cfg.usable_w)
  `SWL_CHECK_IMP(a_height_capped, clk, rst_n, out_valid_r && (out_pos_y_r != slotwin_pkg::HIDDEN_POS), out_drawn_height_r <= cfg.usable_h)
  // A stall freezes every valid bit in the pipe.
  `SWL_CHECK_NXT(a_stall_freezes, clk, rst_n, rst_n && !pipe_en, $stable(pipe_vld))

endmodule

FILE: bench/slot_window_layout_core_tb.sv
module slot_window_layout_core_tb;

  localparam int SLOT_W = slotwin_pkg::SLOT_W;
  localparam int SRC_W = slotwin_pkg::SRC_W;
  localparam int SCALE_W = slotwin_pkg::SCALE_W;
  localparam int ALPHA_W = slotwin_pkg::ALPHA_W;
  localparam int POS_W = slotwin_pkg::POS_W;
  localparam int CFG_IDX_W = slotwin_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = slotwin_pkg::CFG_DATA_W;
  localparam int MARGIN_SIDE = slotwin_pkg::MARGIN_SIDE;
  localparam int MARGIN_TOP = slotwin_pkg::MARGIN_TOP;
  localparam int MARGIN_BOTTOM = slotwin_pkg::MARGIN_BOTTOM;
  localparam logic signed [POS_W-1:0] HIDDEN_POS = slotwin_pkg::HIDDEN_POS;

  // Leave some slack after the last result before finishing.
  localparam int FLUSH_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 190;
  localparam longint UNITY = 1 << slotwin_pkg::UNITY_SHIFT;

  // One window request as presented on the input channel.
  typedef struct packed {
    logic signed [SLOT_W-1:0] slot;
    logic [SRC_W-1:0] width;
    logic [SRC_W-1:0] height;
  } window_req_t;

  // Where and how a window ends up on screen.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SRC_W-1:0] drawn_width;
    logic [SRC_W-1:0] drawn_height;
    logic [ALPHA_W-1:0] opacity;
  } placement_t;

  // Shadow copy of the layout registers.
  typedef struct packed {
    logic [SRC_W-1:0] screen_width;
    logic [SRC_W-1:0] screen_height;
    logic [SCALE_W-1:0] scale_active;
    logic [SCALE_W-1:0] scale_adjacent;
    logic [SCALE_W-1:0] scale_far;
    logic [ALPHA_W-1:0] alpha_active;
    logic [ALPHA_W-1:0] alpha_adjacent;
    logic [ALPHA_W-1:0] alpha_far;
  } layout_regs_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SLOT_W-1:0] in_slot_offset = '0;
  logic [SRC_W-1:0] in_source_width = '0;
  logic [SRC_W-1:0] in_source_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic [SRC_W-1:0] out_drawn_width;
  logic [SRC_W-1:0] out_drawn_height;
  logic [ALPHA_W-1:0] out_opacity;

  layout_regs_t layout_regs;
  window_req_t pending_reqs[$];
  placement_t expected_placements[$];
  logic req_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int issued_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int settings_count = 0;
  int cycle_count = 0;

  slot_window_layout_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_slot_offset(in_slot_offset),
    .in_source_width(in_source_width),
    .in_source_height(in_source_height),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_drawn_width(out_drawn_width),
    .out_drawn_height(out_drawn_height),
    .out_opacity(out_opacity)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Work out the placement of one window under the given register set.
  // Everything is carried in signed 64-bit so no intermediate wraps.
  function automatic placement_t place_window(layout_regs_t r, window_req_t q);
    placement_t p;
    longint slot, src_w, src_h, scr_w, scr_h, scale, alpha;
    longint usable_w, usable_h, dw, dh, px, py;
    bit hidden;
    slot = longint'(q.slot);
    src_w = longint'(q.width);
    src_h = longint'(q.height);
    scr_w = longint'(r.screen_width);
    scr_h = longint'(r.screen_height);
    hidden = 1'b0;
    scale = 0;
    alpha = 0;
    if (slot == 0) begin
      scale = longint'(r.scale_active);
      alpha = longint'(r.alpha_active);
    end else if (slot == 1 || slot == -1) begin
      scale = longint'(r.scale_adjacent);
      alpha = longint'(r.alpha_adjacent);
    end else if (slot == 2 || slot == -2) begin
      scale = longint'(r.scale_far);
      alpha = longint'(r.alpha_far);
    end else begin
      hidden = 1'b1;
    end

    if (hidden) begin
      p.pos_x = HIDDEN_POS;
      p.pos_y = HIDDEN_POS;
      p.drawn_width = '0;
      p.drawn_height = '0;
      p.opacity = '0;
    end else begin
      // A screen no larger than its margins leaves a usable extent of zero.
      usable_w = scr_w - 2 * MARGIN_SIDE;
      usable_h = scr_h - MARGIN_TOP - MARGIN_BOTTOM;
      if (usable_w < 0) usable_w = 0;
      if (usable_h < 0) usable_h = 0;

      dw = (src_w * scale) / UNITY;
      dh = (src_h * scale) / UNITY;
      // Cap width first, then height; the other side follows the aspect ratio.
      if (dw > usable_w) begin
        dh = dh * usable_w / dw;
        dw = usable_w;
      end
      if (dh > usable_h) begin
        dw = dw * usable_h / dh;
        dh = usable_h;
      end

      px = scr_w / 2 + slot * scr_w - dw / 2;
      py = MARGIN_TOP + usable_h / 2 - dh / 2;
      p.pos_x = POS_W'(px);
      p.pos_y = POS_W'(py);
      p.drawn_width = SRC_W'(dw);
      p.drawn_height = SRC_W'(dh);
      p.opacity = ALPHA_W'(alpha);
    end
    return p;
  endfunction

  function automatic logic [SRC_W-1:0] random_extent();
    int pick;
    logic [SRC_W-1:0] v;
    pick = $urandom_range(9);
    if (pick < 4) v = SRC_W'($urandom);
    else if (pick < 6) v = SRC_W'($urandom_range(300));
    else if (pick < 8) v = SRC_W'($urandom_range(1400, 600));
    else if (pick == 8) v = $urandom_range(1) ? '1 : '0;
    else v = SRC_W'($urandom_range(8));
    return v;
  endfunction

  // Mostly visible slots with varied sizes; the rest hidden or at the edges.
  function automatic window_req_t random_request();
    window_req_t q;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      q.slot = SLOT_W'($urandom_range(4) - 2);
    end else if (pick < 85) begin
      q.slot = SLOT_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0: q.slot = 7'sd3;
        1: q.slot = -7'sd3;
        2: q.slot = 7'sd63;
        default: q.slot = -7'sd64;
      endcase
    end
    q.width = random_extent();
    q.height = random_extent();
    return q;
  endfunction

  function automatic layout_regs_t random_regs();
    layout_regs_t r;
    r.screen_width = SRC_W'($urandom_range(4095, 640));
    r.screen_height = SRC_W'($urandom_range(4095, 480));
    r.scale_active = SCALE_W'($urandom_range(1024, 1));
    r.scale_adjacent = SCALE_W'($urandom_range(1024, 1));
    r.scale_far = SCALE_W'($urandom_range(1024, 1));
    r.alpha_active = ALPHA_W'($urandom);
    r.alpha_adjacent = ALPHA_W'($urandom);
    r.alpha_far = ALPHA_W'($urandom);
    return r;
  endfunction

  // Write one register and track it in the shadow copy.
  task automatic write_reg(slotwin_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      slotwin_pkg::REG_SCREEN_WIDTH: layout_regs.screen_width = val;
      slotwin_pkg::REG_SCREEN_HEIGHT: layout_regs.screen_height = val;
      slotwin_pkg::REG_SCALE_ACTIVE: layout_regs.scale_active = val[SCALE_W-1:0];
      slotwin_pkg::REG_SCALE_ADJACENT: layout_regs.scale_adjacent = val[SCALE_W-1:0];
      slotwin_pkg::REG_SCALE_FAR: layout_regs.scale_far = val[SCALE_W-1:0];
      slotwin_pkg::REG_ALPHA_ACTIVE: layout_regs.alpha_active = val[ALPHA_W-1:0];
      slotwin_pkg::REG_ALPHA_ADJACENT: layout_regs.alpha_adjacent = val[ALPHA_W-1:0];
      default: layout_regs.alpha_far = val[ALPHA_W-1:0];
    endcase
  endtask

  task automatic load_layout(layout_regs_t r);
    write_reg(slotwin_pkg::REG_SCREEN_WIDTH, r.screen_width);
    write_reg(slotwin_pkg::REG_SCREEN_HEIGHT, r.screen_height);
    write_reg(slotwin_pkg::REG_SCALE_ACTIVE, CFG_DATA_W'(r.scale_active));
    write_reg(slotwin_pkg::REG_SCALE_ADJACENT, CFG_DATA_W'(r.scale_adjacent));
    write_reg(slotwin_pkg::REG_SCALE_FAR, CFG_DATA_W'(r.scale_far));
    write_reg(slotwin_pkg::REG_ALPHA_ACTIVE, CFG_DATA_W'(r.alpha_active));
    write_reg(slotwin_pkg::REG_ALPHA_ADJACENT, CFG_DATA_W'(r.alpha_adjacent));
    write_reg(slotwin_pkg::REG_ALPHA_FAR, CFG_DATA_W'(r.alpha_far));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic queue_request(logic signed [SLOT_W-1:0] slot,
                               logic [SRC_W-1:0] w, logic [SRC_W-1:0] h);
    window_req_t q;
    q.slot = slot;
    q.width = w;
    q.height = h;
    pending_reqs.push_back(q);
    issued_count++;
  endtask

  // Block until every queued request has been taken and answered.
  task automatic wait_drained();
    while (accepted_count != issued_count || expected_placements.size() != 0)
      @(negedge clk);
  endtask

  // Random requests in two halves; the sender holds off in between until
  // the pipeline has emptied completely.
  task automatic run_random(int n);
    window_req_t q;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      q = random_request();
      queue_request(q.slot, q.width, q.height);
    end
    wait_drained();
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Request driver: present the next pending request once the current one
  // has gone, or drop valid when idling or out of work.
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (rst_n && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_slot_offset <= pending_reqs[0].slot;
        in_source_width <= pending_reqs[0].width;
        in_source_height <= pending_reqs[0].height;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result consumer: stall at random at the configured rate.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    window_req_t q;
    placement_t want;
    req_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      q.slot = in_slot_offset;
      q.width = in_source_width;
      q.height = in_source_height;
      expected_placements.push_back(place_window(layout_regs, q));
      accepted_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_placements.size() == 0) begin
        $display("%0t: result with no request outstanding, got x=%0d y=%0d w=%0d h=%0d a=%0d",
                 $time, out_pos_x, out_pos_y, out_drawn_width, out_drawn_height,
                 out_opacity);
        mismatch_count++;
      end else begin
        want = expected_placements.pop_front();
        check_field("pos_x", int'(want.pos_x), int'(out_pos_x));
        check_field("pos_y", int'(want.pos_y), int'(out_pos_y));
        check_field("drawn_width", int'(want.drawn_width), int'(out_drawn_width));
        check_field("drawn_height", int'(want.drawn_height), int'(out_drawn_height));
        check_field("opacity", int'(want.opacity), int'(out_opacity));
      end
    end
  end

  // Watchdog: abandon the run if it stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_placements.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    layout_regs_t r;
    // Defaults that the block reloads on reset.
    layout_regs.screen_width = 12'd1024;
    layout_regs.screen_height = 12'd768;
    layout_regs.scale_active = 11'd256;
    layout_regs.scale_adjacent = 11'd192;
    layout_regs.scale_far = 11'd128;
    layout_regs.alpha_active = 8'd255;
    layout_regs.alpha_adjacent = 8'd160;
    layout_regs.alpha_far = 8'd80;
    send_idle_pct = 9;
    recv_idle_pct = 88;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    settings_count++;

    // Directed requests under the reset layout (usable area 960 x 672).
    queue_request(7'sd0, 12'd0, 12'd0);
    queue_request(7'sd0, 12'd4095, 12'd4095);
    queue_request(7'sd0, 12'd4095, 12'd1);
    queue_request(7'sd0, 12'd1, 12'd4095);
    queue_request(7'sd0, 12'd960, 12'd672);
    queue_request(7'sd0, 12'd961, 12'd100);
    queue_request(7'sd0, 12'd7, 12'd3000);
    queue_request(7'sd0, 12'd2048, 12'd2048);
    queue_request(7'sd1, 12'd1280, 12'd500);
    queue_request(-7'sd1, 12'd2000, 12'd300);
    queue_request(7'sd1, 12'hAAA, 12'h555);
    queue_request(-7'sd1, 12'h555, 12'hAAA);
    queue_request(7'sd2, 12'd3000, 12'd3000);
    queue_request(-7'sd2, 12'd4095, 12'd0);
    queue_request(7'sd2, 12'd1, 12'd1);
    queue_request(-7'sd2, 12'd4094, 12'd4094);
    queue_request(7'sd3, 12'd100, 12'd100);
    queue_request(-7'sd3, 12'd100, 12'd100);
    queue_request(7'sd63, 12'd4095, 12'd4095);
    queue_request(-7'sd64, 12'd4095, 12'd4095);
    wait_drained();

    // Reset layout, sender mostly busy, receiver mostly stalled.
    run_random(ITEMS_PER_PHASE);

    // Largest screen and scales, full opacity.
    r = '{12'd4095, 12'd4095, 11'd1024, 11'd1024, 11'd1024, 8'd255, 8'd255, 8'd255};
    load_layout(r);
    run_random(ITEMS_PER_PHASE);

    // Swap idling: sender starved, receiver eager.
    send_idle_pct = 88;
    recv_idle_pct = 9;
    // Smallest legal screen and scales, fully transparent.
    r = '{12'd640, 12'd480, 11'd1, 11'd1, 11'd1, 8'd0, 8'd0, 8'd0};
    load_layout(r);
    run_random(ITEMS_PER_PHASE);

    // Screen smaller than its margins, zero scale and the widest scale field.
    r = '{12'd40, 12'd60, 11'd0, 11'd2047, 11'd700, 8'd1, 8'd128, 8'd254};
    load_layout(r);
    run_random(ITEMS_PER_PHASE);

    // No idling on either side from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Screen exactly the size of its margins: usable area collapses to zero.
    r = '{12'd64, 12'd96, 11'd300, 11'd512, 11'd1024, 8'd33, 8'd66, 8'd99};
    load_layout(r);
    run_random(ITEMS_PER_PHASE);

    load_layout(random_regs());
    run_random(ITEMS_PER_PHASE);
    load_layout(random_regs());
    run_random(ITEMS_PER_PHASE);

    wait_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);

    $display("Placed %0d window requests (%0d results) across %0d register layouts,",
             accepted_count, result_count, settings_count);
    $display("including hidden slots, capped sizes and degenerate screens: %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_placements.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
